[design/cbds_pkg.sv]
// Package for the cross blur and decimating scaler: payload structs, register map,
// reset values and the constants of the divide-by-five average.
// No dependencies; every other file in the design folder imports it.
package cbds_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  // Configuration port.
  localparam int CFG_W   = 13;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd3840;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd2160;

  localparam logic [PADDR_W-3:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [PADDR_W-3:0] REG_IMAGE_HEIGHT = 1'b1;

  // Five 8-bit samples sum to at most 1275, and floor(s / 5) equals (s * 52429) >> 18
  // over that whole range.
  localparam int SUM_W       = 11;
  localparam int DIV5_MUL_W  = 16;
  localparam int DIV5_MUL    = 52429;
  localparam int DIV5_SH     = 18;

  localparam int ROW_OUT_W = 10;
  localparam int COL_OUT_W = 10;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  typedef struct packed {
    op_t        operation;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic [ROW_OUT_W-1:0] out_row;
    logic [COL_OUT_W-1:0] out_col;
    logic [7:0]           avg_blue;
    logic [7:0]           avg_green;
    logic [7:0]           avg_red;
  } dest_t;

  // One colour sample, blue in the low byte.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // One column of the line store: the row above and the most recent row.
  typedef struct packed {
    rgb_t older;
    rgb_t newer;
  } line_entry_t;

  // The five samples of one cross.
  typedef struct packed {
    rgb_t ctr;
    rgb_t up;
    rgb_t dn;
    rgb_t lf;
    rgb_t rt;
  } ops_t;

endpackage

[design/cbds_filter.sv]
// Averaging and address mapping stages of the scaler: the sum register stage and the
// output register with its stall logic.
// Depends on cbds_pkg.
module cbds_filter #(
  parameter int MAX_WIDTH  = cbds_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cbds_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  op_valid,
  input  cbds_pkg::ops_t                        ops,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]       op_row,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]        op_col,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]        eff_w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]       eff_h,
  output logic                                  ready,
  output logic                                  dest_valid,
  input  logic                                  dest_stall,
  output cbds_pkg::dest_t                       dest
);
  import cbds_pkg::*;

  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int XW = HW + 1;
  // Reciprocal constants: exact for every operand below 2**XW and 2**WW.
  localparam int K9 = XW + 3;
  localparam int M9 = ((2 ** K9) + 8) / 9;
  localparam int K6 = WW + 3;
  localparam int M6 = ((2 ** K6) + 5) / 6;

  function automatic logic [XW-1:0] div9(input logic [XW-1:0] x);
    logic [XW+K9-1:0] p;
    p = (XW + K9)'(x) * (XW + K9)'(M9);
    return p[K9 +: XW];
  endfunction

  function automatic logic [WW-1:0] div6(input logic [WW-1:0] x);
    logic [WW+K6-1:0] p;
    p = (WW + K6)'(x) * (WW + K6)'(M6);
    return p[K6 +: WW];
  endfunction

  function automatic logic [7:0] div5(input logic [SUM_W-1:0] s);
    logic [SUM_W+DIV5_MUL_W-1:0] p;
    p = (SUM_W + DIV5_MUL_W)'(s) * (SUM_W + DIV5_MUL_W)'(DIV5_MUL);
    return p[DIV5_SH +: 8];
  endfunction

  function automatic logic [SUM_W-1:0] sum5(input logic [7:0] a0, input logic [7:0] a1,
                                            input logic [7:0] a2, input logic [7:0] a3,
                                            input logic [7:0] a4);
    return SUM_W'(a0) + SUM_W'(a1) + SUM_W'(a2) + SUM_W'(a3) + SUM_W'(a4);
  endfunction

  logic             s2_valid;
  logic [SUM_W-1:0] s2_sum_b;
  logic [SUM_W-1:0] s2_sum_g;
  logic [SUM_W-1:0] s2_sum_r;
  logic [XW-1:0]    s2_rowq;
  logic [WW-1:0]    s2_colq;
  logic             s2_odd;
  logic             s2_even;

  logic [XW-1:0]    row_lim;
  logic [WW-1:0]    col_lim;

  logic             out_en;
  logic             s2_en;
  logic [XW-1:0]    orow;
  logic [WW-1:0]    ocol;
  logic             keep;

  assign out_en = ~dest_valid | ~dest_stall;
  assign s2_en  = ~s2_valid | out_en;
  assign ready  = s2_en;

  // Target bounds are registered from the size registers and follow them in the next cycle.
  always_ff @(posedge clk) begin
    row_lim <= div9({eff_h, 1'b0});
    col_lim <= div6(eff_w);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid   <= 1'b0;
      dest_valid <= 1'b0;
    end else begin
      if (s2_en) begin
        s2_valid <= op_valid;
      end
      if (out_en) begin
        dest_valid <= s2_valid & keep;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_sum_b <= sum5(ops.ctr.blue, ops.up.blue, ops.dn.blue, ops.lf.blue, ops.rt.blue);
      s2_sum_g <= sum5(ops.ctr.green, ops.up.green, ops.dn.green, ops.lf.green,
                       ops.rt.green);
      s2_sum_r <= sum5(ops.ctr.red, ops.up.red, ops.dn.red, ops.lf.red, ops.rt.red);
      s2_rowq  <= div9({op_row, 1'b0});
      s2_colq  <= div6(op_col);
      s2_odd   <= op_row[0];
      s2_even  <= op_row[0] ~^ op_col[0];
    end
  end

  // Odd rows land one row down and one column right in the target.
  assign orow = s2_rowq + XW'(s2_odd);
  assign ocol = s2_colq + WW'(s2_odd);
  assign keep = s2_even & (orow < row_lim) & (ocol < col_lim);

  always_ff @(posedge clk) begin
    if (out_en) begin
      dest.out_row   <= ROW_OUT_W'(orow);
      dest.out_col   <= COL_OUT_W'(ocol);
      dest.avg_blue  <= div5(s2_sum_b);
      dest.avg_green <= div5(s2_sum_g);
      dest.avg_red   <= div5(s2_sum_r);
    end
  end

endmodule

[design/cross_blur_decimate_scaler_top.sv]
// Top level of the cross blur and decimating scaler: configuration registers, frame
// counters, the two-row line store and the operand register.
// Depends on cbds_pkg and cbds_filter.
//
//   Channel  | Flow   | Handshake                          | Payload
//   ---------+--------+------------------------------------+---------------------------
//   pixel    | in     | pixel_valid / pixel_stall          | cbds_pkg::pixel_t
//   dest     | out    | dest_valid / dest_stall            | cbds_pkg::dest_t
//   config   | in     | psel, penable, pwrite, pready      | paddr, pwdata, prdata
//
// One request is taken in every clock cycle while dest is not stalled; a result passes through the
// operand register and the sum register into the output register. The rate is set by the
// line store, which does one write and two registered reads in every cycle.
// Reset is synchronous and clears only control state; the line store needs no clearing
// pass, since a column is always written before it is read as a neighbour.
// A stall on dest backs up through three register stages to pixel_stall.
module cross_blur_decimate_scaler_top #(
  parameter int MAX_WIDTH  = cbds_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cbds_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cbds_pkg::PADDR_W-1:0]  paddr,
  input  logic [cbds_pkg::PDATA_W-1:0]  pwdata,
  output logic [cbds_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          pixel_valid,
  output logic                          pixel_stall,
  input  cbds_pkg::pixel_t              pixel,
  output logic                          dest_valid,
  input  logic                          dest_stall,
  output cbds_pkg::dest_t               dest
);
  import cbds_pkg::*;

  // Column counter, effective width and effective height widths.
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int EWW = (WW > CFG_W) ? WW : CFG_W;
  localparam int EHW = (HW > CFG_W) ? HW : CFG_W;

  // Configuration registers and their clamped values.
  logic [CFG_W-1:0]   image_width;
  logic [CFG_W-1:0]   image_height;
  logic [EWW-1:0]     width_ext;
  logic [EHW-1:0]     height_ext;
  logic [WW-1:0]      eff_w;
  logic [HW-1:0]      eff_h;
  logic               cfg_wr;
  logic [PADDR_W-3:0] reg_idx;

  // Frame position. In the drain phase the column counter counts drain requests.
  logic [CW-1:0]      col;
  logic [CW-1:0]      col_next;
  logic [HW-1:0]      row;
  logic [HW-1:0]      row_next;

  // Line store: each column holds the row above and the newest row.
  line_entry_t        line_mem [MAX_WIDTH];
  line_entry_t        rd_a;
  line_entry_t        rd_b;
  line_entry_t        wdata;
  logic [CW-1:0]      addr_a;
  logic [CW-1:0]      addr_b;
  logic               mem_we;

  logic               pix_take;
  logic               is_drain;
  logic               frame_done;
  logic               advance;
  logic [WW-1:0]      col_inc;
  logic               row_end;
  logic               emit_now;
  rgb_t               px;
  rgb_t               prev_ctr;
  ops_t               ops;
  logic [HW-1:0]      r_cur;
  logic               up_is_ctr;

  // Operand register feeding the filter stages.
  logic               s1_valid;
  logic               s1_en;
  ops_t               s1_ops;
  logic [HW-1:0]      s1_r;
  logic [CW-1:0]      s1_c;
  logic               flt_ready;

  // ---------------------------------------------------------------------------
  // Configuration port. Writes take effect on the access cycle; pready is tied high.
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_IMAGE_WIDTH:  image_width  <= pwdata[CFG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_IMAGE_WIDTH:  prdata = PDATA_W'(image_width);
      REG_IMAGE_HEIGHT: prdata = PDATA_W'(image_height);
      default:          prdata = '0;
    endcase
  end

  // A zero register is taken as one, and anything above the build limit as the limit.
  assign width_ext  = EWW'(image_width);
  assign height_ext = EHW'(image_height);

  always_comb begin
    if (image_width == '0) begin
      eff_w = WW'(1);
    end else if (width_ext > EWW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_ext);
    end
    if (image_height == '0) begin
      eff_h = HW'(1);
    end else if (height_ext > EHW'(MAX_HEIGHT)) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(height_ext);
    end
  end

  // ---------------------------------------------------------------------------
  // Request decode. A pixel counts only while the frame is still filling; a drain
  // request counts only after the last row has arrived. Others are dropped silently.
  // ---------------------------------------------------------------------------
  assign s1_en       = ~s1_valid | flt_ready;
  assign pixel_stall = ~s1_en;
  assign pix_take    = pixel_valid & ~pixel_stall;
  assign is_drain    = (pixel.operation == OP_DRAIN);
  assign frame_done  = (row >= eff_h);
  assign advance     = pix_take & (is_drain ? frame_done : ~frame_done);
  assign col_inc     = WW'(col) + WW'(1);
  assign row_end     = (col_inc >= eff_w);

  // The first input row only fills the store; every later pixel finishes the centre
  // above it, and every drain request finishes one centre of the last row.
  assign emit_now = advance & (is_drain | (row != '0));

  always_comb begin
    col_next = col;
    row_next = row;
    if (rst || cfg_wr) begin
      // A register write abandons the frame in progress.
      col_next = '0;
      row_next = '0;
    end else if (advance) begin
      if (row_end) begin
        col_next = '0;
        row_next = is_drain ? '0 : row + HW'(1);
      end else begin
        col_next = CW'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Line store. The reads are issued for the next position so that the centre and
  // right neighbour are already registered when its request arrives. A read of the
  // column being written in the same cycle takes the new data.
  // ---------------------------------------------------------------------------
  assign px     = '{red: pixel.red, green: pixel.green, blue: pixel.blue};
  assign mem_we = advance & ~is_drain;
  assign wdata  = '{older: rd_a.newer, newer: px};
  assign addr_a = col_next;
  assign addr_b = col_next + CW'(1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[col] <= wdata;
    end
    rd_a <= (mem_we && (addr_a == col)) ? wdata : line_mem[addr_a];
    rd_b <= (mem_we && (addr_b == col)) ? wdata : line_mem[addr_b];
  end

  // ---------------------------------------------------------------------------
  // Cross operands. The left neighbour is the previous centre of the same row, kept
  // in a register; at the image border the centre stands in for a missing neighbour.
  // The row above is replaced by the centre on the top row, the row below by the
  // centre on the last row.
  // ---------------------------------------------------------------------------
  assign up_is_ctr = is_drain ? (eff_h == HW'(1)) : (row == HW'(1));
  assign r_cur     = is_drain ? eff_h - HW'(1) : row - HW'(1);

  always_comb begin
    ops.ctr = rd_a.newer;
    ops.up  = up_is_ctr ? rd_a.newer : rd_a.older;
    ops.dn  = is_drain ? rd_a.newer : px;
    ops.lf  = (col == '0) ? rd_a.newer : prev_ctr;
    ops.rt  = row_end ? rd_a.newer : rd_b.newer;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prev_ctr <= rd_a.newer;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= emit_now;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_ops <= ops;
      s1_r   <= r_cur;
      s1_c   <= col;
    end
  end

  // Averaging, address mapping, bound check and the output register.
  cbds_filter #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_filter (
    .clk        (clk),
    .rst        (rst),
    .op_valid   (s1_valid),
    .ops        (s1_ops),
    .op_row     (s1_r),
    .op_col     (WW'(s1_c)),
    .eff_w      (eff_w),
    .eff_h      (eff_h),
    .ready      (flt_ready),
    .dest_valid (dest_valid),
    .dest_stall (dest_stall),
    .dest       (dest)
  );

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for cross_blur_decimate_scaler_top: drives pixel and drain
// requests, programs the frame size over the APB port and checks every write request.
// Depends on cbds_pkg and the design files; it needs nothing else to run.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cbds_pkg::*;

  // Clock period in ns, and the watchdog limit in clock cycles.
  localparam int CLK_PERIOD     = 12;
  localparam int TIMEOUT_CYCLES = 100000;
  localparam int RESET_CYCLES   = 11;

  // Line store depth and frame limits of the predictor; they match the instance below.
  localparam int MAX_W = DEF_MAX_WIDTH;
  localparam int MAX_H = DEF_MAX_HEIGHT;

  // A result passes the operand, sum and output registers, and a stall backs up through
  // three stages, so this many unstalled cycles always empties the pipeline.
  localparam int SETTLE_CYCLES = 8;
  // Cycles to wait for outstanding results before declaring them lost.
  localparam int DRAIN_LIMIT   = 4000;
  localparam int REPORT_LINES  = 40;

  // Target scaling: rows by 2/9, columns by 1/6, and the divide of the five-point sum.
  localparam int ROW_SCALE_NUM = 2;
  localparam int ROW_SCALE_DEN = 9;
  localparam int COL_SCALE_DEN = 6;
  localparam int CROSS_POINTS  = 5;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [PDATA_W-1:0]   pwdata = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;
  logic                 pixel_valid = 1'b0;
  logic                 pixel_stall;
  pixel_t               pixel = '0;
  logic                 dest_valid;
  logic                 dest_stall = 1'b0;
  dest_t                dest;

  // Percentage of cycles in which the source holds back and the sink stalls.
  int unsigned src_idle_pct  = 27;
  int unsigned sink_idle_pct = 27;

  int unsigned error_count = 0;

  // Predictor state: its own copy of the size registers, the two line buffers and the
  // frame position counters. Expected write requests queue up in arrival order.
  logic [CFG_W-1:0] width_reg  = WIDTH_RESET;
  logic [CFG_W-1:0] height_reg = HEIGHT_RESET;
  rgb_t             older_px [MAX_W];
  rgb_t             newer_px [MAX_W];
  int unsigned      row_pos   = 0;
  int unsigned      col_pos   = 0;
  int unsigned      drain_pos = 0;
  dest_t            expected_writes [$];

  cross_blur_decimate_scaler_top #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel      (pixel),
    .dest_valid (dest_valid),
    .dest_stall (dest_stall),
    .dest       (dest)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2.0) clk = ~clk;
  end

  // Watchdog: a hang anywhere (a lost result, a stuck handshake) ends here.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("[FAIL] regression broken");
    $finish;
  end

  // ------------------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------------------

  // A size register of zero means one, and anything above the given limit is cut.
  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned top);
    if (v == 0) return 1;
    if (32'(v) > top) return top;
    return 32'(v);
  endfunction

  function automatic logic [7:0] average5(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] c, input logic [7:0] d,
                                          input logic [7:0] e);
    int unsigned s;
    s = 32'(a) + 32'(b) + 32'(c) + 32'(d) + 32'(e);
    return 8'(s / CROSS_POINTS);
  endfunction

  // Averages one cross and, when the centre has an even coordinate sum and its mapped
  // address falls inside the target image, queues the write request that it causes.
  function automatic void place_average(input int unsigned r, input int unsigned c,
                                        input rgb_t ctr, input rgb_t up, input rgb_t dn,
                                        input rgb_t lf, input rgb_t rt);
    int unsigned w, h, orow, ocol;
    dest_t       d;
    w = clamp_dim(width_reg, MAX_W);
    h = clamp_dim(height_reg, MAX_H);
    if (((r + c) & 1) != 0) return;
    orow = (r * ROW_SCALE_NUM) / ROW_SCALE_DEN;
    ocol = c / COL_SCALE_DEN;
    // Odd rows land one row down and one column right of the even-row mapping.
    if ((r & 1) != 0) begin
      orow++;
      ocol++;
    end
    if (orow >= (h * ROW_SCALE_NUM) / ROW_SCALE_DEN || ocol >= w / COL_SCALE_DEN) return;
    d.out_row   = ROW_OUT_W'(orow);
    d.out_col   = COL_OUT_W'(ocol);
    d.avg_blue  = average5(ctr.blue, up.blue, dn.blue, lf.blue, rt.blue);
    d.avg_green = average5(ctr.green, up.green, dn.green, lf.green, rt.green);
    d.avg_red   = average5(ctr.red, up.red, dn.red, lf.red, rt.red);
    expected_writes.push_back(d);
  endfunction

  // Advances the predictor by one accepted request. A pixel finishes the centre directly
  // above it; a drain tick finishes one centre of the last row.
  function automatic void scale_pixel_request(input pixel_t req);
    int unsigned w, h, c, d, r;
    rgb_t        px, ctr, up, lf, rt;
    w = clamp_dim(width_reg, MAX_W);
    h = clamp_dim(height_reg, MAX_H);
    if (req.operation == OP_PIXEL) begin
      c = col_pos;
      // A pixel beyond the end of the frame waits for the drain and is dropped.
      if (row_pos >= h || c >= w) return;
      px.blue  = req.blue;
      px.green = req.green;
      px.red   = req.red;
      if (row_pos > 0) begin
        r   = row_pos - 1;
        ctr = newer_px[c];
        up  = (r == 0) ? ctr : older_px[c];
        // The left neighbour has already been pushed into the older buffer.
        lf  = (c > 0) ? older_px[c - 1] : ctr;
        rt  = (c + 1 < w) ? newer_px[c + 1] : ctr;
        place_average(r, c, ctr, up, px, lf, rt);
      end
      older_px[c] = newer_px[c];
      newer_px[c] = px;
      col_pos = c + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
    end else begin
      d = drain_pos;
      // A drain tick before the frame is complete does nothing.
      if (row_pos < h || d >= w) return;
      ctr = newer_px[d];
      up  = (h == 1) ? ctr : older_px[d];
      lf  = (d > 0) ? newer_px[d - 1] : ctr;
      rt  = (d + 1 < w) ? newer_px[d + 1] : ctr;
      place_average(h - 1, d, ctr, up, ctr, lf, rt);
      drain_pos = d + 1;
      if (drain_pos >= w) begin
        row_pos   = 0;
        col_pos   = 0;
        drain_pos = 0;
      end
    end
  endfunction

  // Any register write restarts the frame from the top-left pixel.
  function automatic void apply_register(input logic [PADDR_W-3:0] sel,
                                         input logic [CFG_W-1:0] value);
    if (sel == REG_IMAGE_WIDTH) width_reg = value;
    else height_reg = value;
    row_pos   = 0;
    col_pos   = 0;
    drain_pos = 0;
  endfunction

  // Every request accepted by the block goes through the predictor at the same edge.
  always @(posedge clk) begin
    if (!rst && pixel_valid && !pixel_stall) scale_pixel_request(pixel);
  end

  // ------------------------------------------------------------------------------------
  // Result checking
  // ------------------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= REPORT_LINES) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  always @(posedge clk) begin : check_dest
    dest_t want;
    if (!rst && dest_valid && !dest_stall) begin
      if (expected_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected write to (%0d, %0d)", dest.out_row,
                                  dest.out_col));
      end else begin
        want = expected_writes.pop_front();
        if (dest.out_row !== want.out_row)
          report_mismatch($sformatf("out_row %0d, expected %0d", dest.out_row,
                                    want.out_row));
        if (dest.out_col !== want.out_col)
          report_mismatch($sformatf("out_col %0d, expected %0d", dest.out_col,
                                    want.out_col));
        if (dest.avg_blue !== want.avg_blue)
          report_mismatch($sformatf("avg_blue %0d, expected %0d at (%0d, %0d)",
                                    dest.avg_blue, want.avg_blue, want.out_row,
                                    want.out_col));
        if (dest.avg_green !== want.avg_green)
          report_mismatch($sformatf("avg_green %0d, expected %0d at (%0d, %0d)",
                                    dest.avg_green, want.avg_green, want.out_row,
                                    want.out_col));
        if (dest.avg_red !== want.avg_red)
          report_mismatch($sformatf("avg_red %0d, expected %0d at (%0d, %0d)",
                                    dest.avg_red, want.avg_red, want.out_row,
                                    want.out_col));
      end
    end
  end

  // The sink stalls at random; the rate is lowered to zero for the steady stretch.
  always @(posedge clk) begin
    dest_stall <= ($urandom_range(99) < sink_idle_pct);
  end

  // ------------------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------------------

  // Channel values lean toward the rails so that sums of all zeros and all ones occur.
  function automatic logic [7:0] channel_value();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic pixel_t make_pixel(input logic [7:0] b, input logic [7:0] g,
                                        input logic [7:0] r);
    pixel_t p;
    p.operation = OP_PIXEL;
    p.blue      = b;
    p.green     = g;
    p.red       = r;
    return p;
  endfunction

  function automatic pixel_t pixel_request();
    return make_pixel(channel_value(), channel_value(), channel_value());
  endfunction

  // The colour of a drain tick is ignored by the block, so it carries random bits.
  function automatic pixel_t drain_request();
    pixel_t p;
    p           = pixel_t'($urandom);
    p.operation = OP_DRAIN;
    return p;
  endfunction

  // Mostly sizes that give a handful of target pixels, some too small for any output and
  // some a little larger.
  function automatic logic [CFG_W-1:0] random_dim(input int unsigned lo, input int unsigned hi);
    case ($urandom_range(9))
      0:       return CFG_W'($urandom_range(lo - 1));
      1:       return CFG_W'($urandom_range(hi + 1, hi + 24));
      default: return CFG_W'($urandom_range(lo, hi));
    endcase
  endfunction

  // Presents one request and holds it until the block takes it, with random idle cycles
  // in front. Valid is only lowered when a gap is actually inserted.
  task automatic send_request(input pixel_t req);
    while ($urandom_range(99) < src_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= req;
    do @(posedge clk); while (pixel_stall);
  endtask

  // Stops the source, waits until every expected result has left, then lets the pipeline
  // run empty, since requests that cause no result may still be in flight.
  task automatic wait_for_quiet();
    int unsigned waited, calm;
    waited = 0;
    calm   = 0;
    pixel_valid <= 1'b0;
    while (expected_writes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_writes.size() != 0) begin
      report_mismatch($sformatf("%0d expected writes never arrived", expected_writes.size()));
      expected_writes.delete();
    end
    while (calm < SETTLE_CYCLES) begin
      @(posedge clk);
      if (!dest_stall) calm++;
    end
  endtask

  // One APB write: setup cycle, then access cycle until pready. The upper data bits are
  // random, as the register only keeps its low bits.
  task automatic write_register(input logic [PADDR_W-3:0] sel, input logic [CFG_W-1:0] value);
    wait_for_quiet();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= {(PDATA_W - CFG_W)'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_register(sel, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Streams the first 'limit' requests of a frame at the current size: all its pixels,
  // then one drain tick per column. With 'noisy' set, requests that the block must ignore
  // are mixed in: drain ticks while the frame is still filling and pixels during the drain.
  task automatic stream_frame(input int unsigned limit, input bit noisy);
    int unsigned w, h, k;
    w = clamp_dim(width_reg, MAX_W);
    h = clamp_dim(height_reg, MAX_H);
    for (k = 0; k < limit; k++) begin
      if (noisy && $urandom_range(24) == 0)
        send_request((k < w * h) ? drain_request() : pixel_request());
      send_request((k < w * h) ? pixel_request() : drain_request());
    end
  endtask

  // ------------------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------------------

  // At the reset size (3840 by 2160) a few pixels go in and cannot finish any centre.
  // The drain ticks land before the frame is complete, so they are ignored.
  task automatic test_reset_defaults();
    send_request(drain_request());
    send_request(make_pixel(8'h00, 8'h00, 8'h00));
    send_request(make_pixel(8'hFF, 8'hFF, 8'hFF));
    send_request(make_pixel(8'h55, 8'hAA, 8'h0F));
    send_request(make_pixel(8'hAA, 8'h55, 8'hF0));
    send_request(drain_request());
  endtask

  // Zero sizes behave as one, giving a one-pixel frame. A second pixel before the drain
  // is dropped, and a drain tick on a fresh frame does nothing. A single-row frame then
  // uses the centre itself as both the up and the down neighbour.
  task automatic test_degenerate_sizes();
    write_register(REG_IMAGE_WIDTH, 0);
    write_register(REG_IMAGE_HEIGHT, 0);
    send_request(pixel_request());
    send_request(pixel_request());
    send_request(drain_request());
    send_request(drain_request());
    write_register(REG_IMAGE_WIDTH, 1);
    write_register(REG_IMAGE_HEIGHT, 1);
    stream_frame(2, 1'b0);
    write_register(REG_IMAGE_WIDTH, 6);
    stream_frame(12, 1'b0);
  endtask

  // Random frames, back to back where no register changes. About one frame in eight is
  // cut short by a register write, which must restart the frame. Only requests that
  // belong to a frame count toward the quota.
  task automatic test_random_frames(input int unsigned quota, input int unsigned idle_pct);
    int unsigned sent, total, limit, sel;
    bit          mid_frame;
    sent      = 0;
    mid_frame = 1'b1;
    src_idle_pct  = idle_pct;
    sink_idle_pct = idle_pct;
    while (sent < quota) begin
      sel = $urandom_range(3);
      if (mid_frame && sel == 0) sel = 3;
      if ((sel & 1) != 0) write_register(REG_IMAGE_WIDTH, random_dim(6, 40));
      if ((sel & 2) != 0) write_register(REG_IMAGE_HEIGHT, random_dim(5, 14));
      total = clamp_dim(width_reg, MAX_W) * (clamp_dim(height_reg, MAX_H) + 1);
      limit = (total > 1 && $urandom_range(7) == 0) ? $urandom_range(1, total - 1) : total;
      stream_frame(limit, 1'b1);
      sent     += limit;
      mid_frame = (limit < total);
    end
    src_idle_pct  = 27;
    sink_idle_pct = 27;
  endtask

  // Full line store width: the top register bit is set and clamped to the store depth.
  // The leading part of the first row fills the store, and the next register write
  // abandons the frame.
  task automatic test_widest_frame();
    write_register(REG_IMAGE_HEIGHT, 5);
    write_register(REG_IMAGE_WIDTH, 4096);
    write_register(REG_IMAGE_WIDTH, 8191);
    stream_frame(96, 1'b0);
  endtask

  // Clamped frame height with a narrow line: the first rows of a frame that is far from
  // complete, so every request is a pixel.
  task automatic test_tallest_frame();
    write_register(REG_IMAGE_WIDTH, 6);
    write_register(REG_IMAGE_HEIGHT, 4096);
    write_register(REG_IMAGE_HEIGHT, 8191);
    stream_frame(6 * 16, 1'b0);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_degenerate_sizes();
    // A stretch with neither side idling, then the main random run with idling.
    test_random_frames(150, 0);
    test_random_frames(650, 27);
    test_widest_frame();
    test_tallest_frame();

    wait_for_quiet();
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
